>>> design/polynomial_newton_root_refiner_assert.svh
// Assertion macros for the Newton root refiner checker.
// Included by the checker module; no other dependencies.
`ifndef POLYNOMIAL_NEWTON_ROOT_REFINER_ASSERT_SVH
`define POLYNOMIAL_NEWTON_ROOT_REFINER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PNR_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define PNR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> design/pnr_pkg.sv
// Package for the Newton root refiner: widths, types, saturation helpers.
// No dependencies.
package pnr_pkg;
  localparam int DefMaxDegree = 6;
  localparam int DefMaxSteps  = 64;
  localparam int NumCoeff     = 7;
  localparam int AddrW        = 5;

  localparam logic [1:0] STATUS_CONV  = 2'd0;
  localparam logic [1:0] STATUS_DZERO = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  localparam logic [2:0] REG_TOL = 3'd7;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // take start_x
    logic horner_init; // acc <= 0 at the start of a Horner pass
    logic deriv;      // evaluating derivative
    logic mul;        // register acc*x
    logic acc_upd;    // acc <= sat(floor(prod)) + coeff
    logic save_p;
    logic save_dp;
    logic div_start;
    logic div_step;
    logic update_x;
  } pnr_cmd_t;

  typedef struct packed {
    logic dp_zero;
    logic div_done;
    logic conv;
  } pnr_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

>>> design/pnr_datapath.sv
// Datapath: x register, Horner multiply/accumulate, restoring divider.
// Uses pnr_pkg.
module pnr_datapath (
  input  logic                clk,
  input  logic signed [31:0]  start_x,
  input  logic signed [15:0]  coeffs [pnr_pkg::NumCoeff],
  input  logic [16:0]         tolerance,
  input  logic [2:0]          coeff_idx,
  input  pnr_pkg::pnr_cmd_t   cmd,
  output pnr_pkg::pnr_sts_t   sts,
  output logic signed [31:0]  x
);
  logic signed [31:0] acc, p, dp;
  logic signed [63:0] prod;
  logic signed [31:0] cval;
  logic signed [31:0] xn;
  // divider: |p|*65536 (48 bits) / |dp|
  logic [47:0] dvd;
  logic [31:0] dvs;
  logic [48:0] rem;
  logic [47:0] quo;
  logic        neg;
  logic [5:0]  dcnt;
  logic [48:0] trial;
  logic signed [49:0] qs;
  logic signed [32:0] diff;
  logic [32:0] adiff;

  // coefficient (times its index for p'), scaled to Q16.16 and saturated
  always_comb begin
    logic signed [19:0] cm;
    cm = 20'(coeffs[coeff_idx])
       * (cmd.deriv ? 20'($signed({1'b0, coeff_idx})) : 20'sd1);
    cval = pnr_pkg::sat32(64'(cm) <<< 16);
  end

  assign trial = {rem[47:0], dvd[47]} - {17'd0, dvs};
  assign qs = neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
  assign xn = pnr_pkg::sat32(64'(x) - 64'(pnr_pkg::sat32(64'(qs))));
  assign diff = 33'(xn) - 33'(x);
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk) begin
    if (cmd.load) x <= start_x;
    if (cmd.horner_init) acc <= '0;
    if (cmd.mul) prod <= 64'(acc) * 64'(x);
    if (cmd.acc_upd)
      acc <= pnr_pkg::sat32(64'(pnr_pkg::sat32(prod >>> 16)) + 64'(cval));
    if (cmd.save_p) p <= acc;
    if (cmd.save_dp) dp <= acc;
    if (cmd.div_start) begin
      dvd  <= {(p[31] ? 32'(-p) : 32'(p)), 16'd0};
      dvs  <= dp[31] ? 32'(-dp) : 32'(dp);
      neg  <= p[31] ^ dp[31];
      rem  <= '0;
      quo  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[48]) begin
        rem <= trial;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= {rem[47:0], dvd[47]};
        quo <= {quo[46:0], 1'b0};
      end
      dvd  <= {dvd[46:0], 1'b0};
      dcnt <= dcnt + 6'd1;
    end
    if (cmd.update_x) x <= xn;
  end

  assign sts.dp_zero  = (dp == 32'sd0);
  assign sts.div_done = (dcnt == 6'd48);
  assign sts.conv     = (adiff <= 33'(tolerance));
endmodule

>>> design/pnr_ctrl.sv
// Controller state machine: sequences Horner passes, division and the result.
// Uses pnr_pkg.
module pnr_ctrl #(
  parameter int MAX_DEGREE = pnr_pkg::DefMaxDegree,
  parameter int MAX_STEPS  = pnr_pkg::DefMaxSteps
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pnr_pkg::pnr_sts_t sts,
  output pnr_pkg::pnr_cmd_t cmd,
  output logic [2:0]        coeff_idx,
  output logic [1:0]        status,
  output logic [6:0]        steps_used
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_INIT = 7'b0000010, S_MUL = 7'b0000100,
    S_ACC  = 7'b0001000, S_DIV0 = 7'b0010000, S_DIV = 7'b0100000,
    S_UPD  = 7'b1000000
  } state_t;
  localparam int SW = $clog2(MAX_STEPS + 1);
  state_t state, state_next;
  logic deriv;
  logic [2:0] idx;
  logic [SW-1:0] steps;
  logic busy;
  logic div_first;
  logic last_step;

  assign in_stall  = busy || out_valid;
  assign coeff_idx = idx;
  assign last_step = (SW'(steps + 1'b1) == SW'(MAX_STEPS));

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.deriv = deriv;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load = 1'b1; state_next = S_INIT;
      end
      S_INIT: begin cmd.horner_init = 1'b1; state_next = S_MUL; end
      S_MUL:  begin cmd.mul = 1'b1; state_next = S_ACC; end
      S_ACC: begin
        cmd.acc_upd = 1'b1;
        state_next = (idx == (deriv ? 3'd1 : 3'd0)) ? S_DIV0 : S_MUL;
      end
      S_DIV0: begin
        if (!deriv) begin
          cmd.save_p = 1'b1; state_next = S_INIT;
        end else begin
          cmd.save_dp = 1'b1; state_next = S_DIV;
        end
      end
      // first cycle loads the divider from the saved p and p', unless p' is zero
      S_DIV: begin
        if (sts.dp_zero) state_next = S_IDLE;
        else if (div_first) cmd.div_start = 1'b1;
        else if (sts.div_done) state_next = S_UPD;
        else cmd.div_step = 1'b1;
      end
      S_UPD: begin
        cmd.update_x = 1'b1;
        state_next = (sts.conv || last_step) ? S_IDLE : S_INIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; out_valid <= 1'b0;
      deriv <= 1'b0; idx <= 3'd0; steps <= '0; div_first <= 1'b0;
      status <= '0; steps_used <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.load) begin busy <= 1'b1; deriv <= 1'b0; steps <= '0; end
      if (state == S_INIT) idx <= 3'(MAX_DEGREE);
      if (cmd.acc_upd && state_next == S_MUL) idx <= idx - 3'd1;
      if (cmd.save_p) deriv <= 1'b1;
      if (cmd.save_dp) begin deriv <= 1'b0; div_first <= 1'b1; end
      if (state == S_DIV) div_first <= 1'b0;
      if (state == S_DIV && sts.dp_zero) begin
        busy <= 1'b0; out_valid <= 1'b1; status <= pnr_pkg::STATUS_DZERO;
        steps_used <= (32'(steps) > 127) ? 7'd127 : 7'(steps);
      end
      if (cmd.update_x) begin
        steps <= steps + 1'b1;
        if (sts.conv || last_step) begin
          busy <= 1'b0; out_valid <= 1'b1;
          status <= sts.conv ? pnr_pkg::STATUS_CONV : pnr_pkg::STATUS_LIMIT;
          steps_used <= (32'(steps) + 1 > 127) ? 7'd127 : 7'(steps + 1'b1);
        end
      end
    end
  end
endmodule

>>> design/polynomial_newton_root_refiner.sv
// Top level: APB registers, pnr_ctrl and pnr_datapath; uses pnr_pkg.
// Newton step: Horner pass for p, Horner pass for p', divider load + 48 shifts + finish,
// then x update; the divider sets the step length. Result valid after at most MAX_STEPS
// Newton steps; a zero derivative ends its step before the division. One item at a
// time: the next input is taken only once the result has been accepted.
// Sync reset clears control state, coefficients to 0 and tolerance to 1.
module polynomial_newton_root_refiner #(
  parameter int MAX_DEGREE = pnr_pkg::DefMaxDegree,
  parameter int MAX_STEPS  = pnr_pkg::DefMaxSteps
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pnr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [31:0]        start_x,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        root_x,
  output logic [1:0]                status,
  output logic [6:0]                steps_used
);
  logic signed [15:0] coeffs [pnr_pkg::NumCoeff];
  logic [16:0] tolerance;
  logic [2:0] ridx;
  pnr_pkg::pnr_cmd_t cmd;
  pnr_pkg::pnr_sts_t sts;
  logic [2:0] coeff_idx;
  logic [1:0] st_q;
  logic signed [31:0] x;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  // register file: coefficients then tolerance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pnr_pkg::NumCoeff; i++) coeffs[i] <= '0;
      tolerance <= 17'd1;
    end else if (psel && penable && pwrite) begin
      if (ridx == pnr_pkg::REG_TOL) tolerance <= pwdata[16:0];
      else coeffs[ridx] <= pwdata[15:0];
    end
  end

  always_comb begin
    if (ridx == pnr_pkg::REG_TOL) prdata = {15'd0, tolerance};
    else prdata = 32'(coeffs[ridx]);
  end

  pnr_ctrl #(.MAX_DEGREE(MAX_DEGREE), .MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .coeff_idx, .status(st_q), .steps_used
  );

  // division starts in the cycle after dp is saved; dp_zero checked then
  pnr_datapath u_dp (
    .clk, .start_x, .coeffs, .tolerance, .coeff_idx, .cmd, .sts, .x
  );

  assign root_x = x;
  assign status = st_q;
endmodule

>>> design/pnr_checker.sv
// Port-level checker for the Newton root refiner, bound to the top level.
// Uses polynomial_newton_root_refiner_assert.svh.
`include "polynomial_newton_root_refiner_assert.svh"
module pnr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [6:0]  steps_used,
  input logic [31:0] root_x
);
  `PNR_ASSERT_IMP(a_status_code, out_valid, status <= pnr_pkg::STATUS_LIMIT)
  `PNR_ASSERT_IMP(a_busy_while_result, out_valid, in_stall)
  `PNR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(root_x))
  `PNR_ASSERT_NEXT(a_fields_hold, out_valid && out_stall, $stable({status, steps_used}))
  `PNR_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
endmodule

bind polynomial_newton_root_refiner pnr_checker u_pnr_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .steps_used, .root_x
);
